>>> src/xsrru_pkg.sv
// Shared types, constants and functions of the xorshift random request unit.
package xsrru_pkg;

   localparam int MODE_W  = 3;
   localparam int SEED_W  = 16;
   localparam int BOUND_W = 8;
   localparam int HALF_W  = 7;
   localparam int MASK_W  = 16;
   localparam int VALUE_W = 16;
   localparam int SVAL_W  = 8;
   localparam int STATE_W = 32;

   // Modulo unit: byte dividend, divisor up to 256.
   localparam int DIVIDEND_W = 8;
   localparam int DIVISOR_W  = 9;

   localparam logic [STATE_W-1:0] GOLDEN_MIX = 32'h9E37_79B9;
   localparam logic [BOUND_W-1:0] PCT_BASE   = 8'd100;

   typedef enum logic [MODE_W-1:0] {
      MODE_RESEED = 3'd0,
      MODE_WORD   = 3'd1,
      MODE_BYTE   = 3'd2,
      MODE_RANGE  = 3'd3,
      MODE_CHANCE = 3'd4,
      MODE_SIGNED = 3'd5,
      MODE_PICK   = 3'd6
   } mode_type;

   function automatic logic [STATE_W-1:0] xs_step(input logic [STATE_W-1:0] x);
      logic [STATE_W-1:0] a;
      logic [STATE_W-1:0] b;
      a = x ^ (x << 13);
      b = a ^ (a >> 17);
      return b ^ (b << 5);
   endfunction

   // Number of set bits of a 16-bit mask, summed nibble by nibble.
   function automatic logic [4:0] popcount16(input logic [MASK_W-1:0] m);
      logic [4:0] total;
      total = 5'd0;
      for (int n = 0; n < MASK_W / 4; n++) begin
         total = total + 5'(m[4*n]) + 5'(m[4*n+1]) + 5'(m[4*n+2]) + 5'(m[4*n+3]);
      end
      return total;
   endfunction

   // Generator contents after reset: reseeding with seed zero uses seed one.
   localparam logic [STATE_W-1:0] RESET_STATE = xs_step(32'h0000_0001 ^ GOLDEN_MIX);

endpackage

>>> src/xsrru_if.sv
// Request and response channel interfaces of the xorshift random request unit.
interface xsrru_req_if import xsrru_pkg::*;;
   logic               valid;
   logic               ready;
   logic [MODE_W-1:0]  mode;
   logic [SEED_W-1:0]  seed;
   logic [BOUND_W-1:0] low_bound;
   logic [BOUND_W-1:0] high_bound;
   logic [BOUND_W-1:0] percent;
   logic [HALF_W-1:0]  half_span;
   logic [MASK_W-1:0]  bit_mask;

   modport source (output valid, mode, seed, low_bound, high_bound, percent, half_span,
                   bit_mask, input ready);
   modport sink (input valid, mode, seed, low_bound, high_bound, percent, half_span,
                 bit_mask, output ready);
endinterface

interface xsrru_rsp_if import xsrru_pkg::*;;
   logic                     valid;
   logic                     ready;
   logic [VALUE_W-1:0]       value;
   logic signed [SVAL_W-1:0] signed_value;

   modport source (output valid, value, signed_value, input ready);
   modport sink (input valid, value, signed_value, output ready);
endinterface

>>> src/xorshift_random_request_unit_core.sv
// Direct modes and degenerate arguments go from the accepted request straight to the
// response load; range, chance and signed first run eight modulo steps and the done strobe,
// and pick adds a scan of up to 16 mask bits after the modulo unit finishes.
// Requests do not overlap; the next request is taken the cycle after the result loads the
// response register, so only a second result waits.
// Synchronous reset loads the generator as if reseeded with seed zero.
module xorshift_random_request_unit_core import xsrru_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   xsrru_req_if.sink   req_chan,
   xsrru_rsp_if.source rsp_chan
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type                state_ff, state_in;
   logic [STATE_W-1:0]       gen_ff, gen_in;
   logic [MODE_W-1:0]        mode_ff, mode_in;
   logic [BOUND_W-1:0]       lo_ff, lo_in;
   logic [BOUND_W-1:0]       pct_ff, pct_in;
   logic [HALF_W-1:0]        hs_ff, hs_in;
   logic [MASK_W-1:0]        mask_ff, mask_in;
   logic [VALUE_W-1:0]       value_ff, value_in;
   logic signed [SVAL_W-1:0] sval_ff, sval_in;
   logic [3:0]               target_ff, target_in;
   logic [3:0]               idx_ff, idx_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [VALUE_W-1:0]       rsp_value_ff, rsp_value_in;
   logic signed [SVAL_W-1:0] rsp_sval_ff, rsp_sval_in;

   logic                     accept;
   logic [STATE_W-1:0]       seed_mix;
   logic [STATE_W-1:0]       step_src;
   logic [STATE_W-1:0]       stepped;
   logic [DIVIDEND_W-1:0]    draw;
   logic                     div_start;
   logic [DIVISOR_W-1:0]     div_divisor;
   logic                     div_busy;
   logic                     div_done;
   logic [DIVIDEND_W-1:0]    div_rem;

   assign accept = req_chan.valid && (state_ff == ST_IDLE);

   // The single step unit serves both reseeding and advancing.
   always_comb begin
      seed_mix = {16'h0000, (req_chan.seed == '0) ? 16'd1 : req_chan.seed} ^ GOLDEN_MIX;
      step_src = ((state_ff == ST_IDLE) && (mode_type'(req_chan.mode) == MODE_RESEED))
                 ? seed_mix : gen_ff;
      stepped  = xs_step(step_src);
      draw     = stepped[STATE_W-1 -: DIVIDEND_W];
   end

   xsrru_mod_unit u_mod (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (draw),
      .divisor   (div_divisor),
      .busy      (div_busy),
      .done      (div_done),
      .remainder (div_rem)
   );

   always_comb begin
      state_in     = state_ff;
      gen_in       = gen_ff;
      mode_in      = mode_ff;
      lo_in        = lo_ff;
      pct_in       = pct_ff;
      hs_in        = hs_ff;
      mask_in      = mask_ff;
      value_in     = value_ff;
      sval_in      = sval_ff;
      target_in    = target_ff;
      idx_in       = idx_ff;
      div_start    = 1'b0;
      div_divisor  = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_value_in = rsp_value_ff;
      rsp_sval_in  = rsp_sval_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mode_in  = req_chan.mode;
               lo_in    = req_chan.low_bound;
               pct_in   = req_chan.percent;
               hs_in    = req_chan.half_span;
               mask_in  = req_chan.bit_mask;
               value_in = '0;
               sval_in  = '0;
               state_in = ST_FINISH;
               unique case (mode_type'(req_chan.mode))
                  MODE_RESEED: gen_in = stepped;
                  MODE_WORD: begin
                     gen_in   = stepped;
                     value_in = stepped[STATE_W-1 -: VALUE_W];
                  end
                  MODE_BYTE: begin
                     gen_in   = stepped;
                     value_in = VALUE_W'(draw);
                  end
                  MODE_RANGE: begin
                     if (req_chan.high_bound <= req_chan.low_bound) begin
                        value_in = VALUE_W'(req_chan.low_bound);
                     end else begin
                        gen_in      = stepped;
                        div_start   = 1'b1;
                        div_divisor = {1'b0, req_chan.high_bound}
                                      - {1'b0, req_chan.low_bound} + DIVISOR_W'(1);
                        state_in    = ST_DIV;
                     end
                  end
                  MODE_CHANCE: begin
                     if (req_chan.percent == '0) begin
                        value_in = '0;
                     end else if (req_chan.percent >= PCT_BASE) begin
                        value_in = VALUE_W'(1);
                     end else begin
                        gen_in      = stepped;
                        div_start   = 1'b1;
                        div_divisor = {1'b0, PCT_BASE};
                        state_in    = ST_DIV;
                     end
                  end
                  MODE_SIGNED: begin
                     if (req_chan.half_span != '0) begin
                        gen_in      = stepped;
                        div_start   = 1'b1;
                        div_divisor = {1'b0, req_chan.half_span, 1'b1};
                        state_in    = ST_DIV;
                     end
                  end
                  MODE_PICK: begin
                     if (req_chan.bit_mask != '0) begin
                        gen_in      = stepped;
                        div_start   = 1'b1;
                        div_divisor = DIVISOR_W'(popcount16(req_chan.bit_mask));
                        state_in    = ST_DIV;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_FINISH;
               unique case (mode_type'(mode_ff))
                  MODE_RANGE:  value_in = VALUE_W'(BOUND_W'(lo_ff + div_rem));
                  MODE_CHANCE: value_in = VALUE_W'(div_rem < pct_ff);
                  MODE_SIGNED: sval_in  = SVAL_W'(div_rem - {1'b0, hs_ff});
                  MODE_PICK: begin
                     // The draw selects which set bit, counting upward from bit 0.
                     target_in = div_rem[3:0];
                     idx_in    = '0;
                     state_in  = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            idx_in = idx_ff + 4'd1;
            if (mask_ff[idx_ff]) begin
               if (target_ff == '0) begin
                  value_in = VALUE_W'(idx_ff);
                  state_in = ST_FINISH;
               end else begin
                  target_in = target_ff - 4'd1;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = value_ff;
               rsp_sval_in  = sval_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_ff       <= RESET_STATE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_ff       <= gen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mode_ff      <= mode_in;
      lo_ff        <= lo_in;
      pct_ff       <= pct_in;
      hs_ff        <= hs_in;
      mask_ff      <= mask_in;
      value_ff     <= value_in;
      sval_ff      <= sval_in;
      target_ff    <= target_in;
      idx_ff       <= idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_sval_ff  <= rsp_sval_in;
   end

   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.value        = rsp_value_ff;
   assign rsp_chan.signed_value = rsp_sval_ff;

   // A request leaves the idle state, so no second request enters behind it.
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != ST_IDLE))
      else $error("request accepted but sequencer stayed idle");

   // The modulo unit is only started when it is free.
   a_mod_start_free: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_busy)
      else $error("modulo unit started while busy");

   // Only signed mode drives the signed field, and it leaves the unsigned one zero.
   a_signed_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_sval_ff != '0)) |-> (rsp_value_ff == '0))
      else $error("both result fields nonzero");

endmodule

>>> src/xsrru_mod_unit.sv
// Restoring modulo unit: one remainder bit per cycle, byte dividend.
module xsrru_mod_unit import xsrru_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  busy,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] remainder
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dvs_ff, dvs_in;
   logic [DIVIDEND_W-1:0] dvd_ff, dvd_in;
   logic [DIVISOR_W:0]    trial;
   logic                  fits;
   logic                  last;

   always_comb begin
      trial = {rem_ff, dvd_ff[DIVIDEND_W-1]};
      fits  = trial >= {1'b0, dvs_ff};
      last  = busy_ff && (cnt_ff == CNT_W'(1));
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      dvd_in  = dvd_ff;
      done_in = last;
      if (start) begin
         cnt_in  = CNT_W'(DIVIDEND_W);
         busy_in = 1'b1;
         rem_in  = '0;
         dvs_in  = divisor;
         dvd_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = fits ? DIVISOR_W'(trial - {1'b0, dvs_ff}) : trial[DIVISOR_W-1:0];
         dvd_in  = dvd_ff << 1;
         cnt_in  = cnt_ff - CNT_W'(1);
         busy_in = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      dvd_ff <= dvd_in;
   end

   assign busy      = busy_ff;
   assign done      = done_ff;
   // The remainder stays below the byte dividend's range.
   assign remainder = rem_ff[DIVIDEND_W-1:0];

endmodule
